[design/snell_refraction_vector_macros.svh]
// assertion macros for the refraction pipeline
`ifndef SNELL_REFRACTION_VECTOR_MACROS_SVH
`define SNELL_REFRACTION_VECTOR_MACROS_SVH
// same-cycle implication, checked at every rising edge out of reset
`define SNR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snr assertion failed");
// next-cycle implication
`define SNR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snr assertion failed");
`endif

[design/snr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and helpers of the refraction pipeline
package snr_pkg;

  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 32;
  localparam int UNIT_LAT    = 6 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int MID_LAT     = 4 + SQRT_STEPS + 4 + SQRT_STEPS + 3;
  localparam int TOP_LAT     = 2 * UNIT_LAT + MID_LAT;
  localparam int IN_TDATA_W  = 256;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;
  localparam int TUSER_TIR   = 0;
  localparam int TUSER_DEG   = 1;

  localparam logic [63:0] ONE_Q60  = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;
  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [31:0] ETA_MAX  = 32'hFFFF_FFFF;

  // one step of the bit-pair square root
  typedef struct packed {
    logic [63:0] x;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  // one step of the restoring divider
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
    logic [31:0] dvs;
  } dv_t;

  function automatic logic [5:0] msb_pos(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

[design/snr_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// one bit of a pipelined integer square root
module snr_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  snr_pkg::sq_t  cell_i,
  output snr_pkg::sq_t  cell_o
);

  logic [35:0]  t;
  logic [35:0]  trial;
  logic [35:0]  diff;
  logic         ge;
  snr_pkg::sq_t cell_nxt;
  snr_pkg::sq_t cell_r;

  always_comb begin
    t             = {cell_i.rem, cell_i.x[63:62]};
    trial         = {2'b00, cell_i.root, 2'b01};
    diff          = t - trial;
    ge            = (t >= trial);
    cell_nxt.x    = {cell_i.x[61:0], 2'b00};
    cell_nxt.rem  = ge ? diff[33:0] : t[33:0];
    cell_nxt.root = {cell_i.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

[design/snr_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// one quotient bit of a pipelined restoring divider
module snr_div_cell (
  input  logic          clk,
  input  logic          en,
  input  snr_pkg::dv_t  cell_i,
  output snr_pkg::dv_t  cell_o
);

  logic [32:0]  t;
  logic [32:0]  diff;
  logic         ge;
  snr_pkg::dv_t cell_nxt;
  snr_pkg::dv_t cell_r;

  always_comb begin
    t            = {cell_i.rem, cell_i.lo[31]};
    diff         = t - {1'b0, cell_i.dvs};
    ge           = (t >= {1'b0, cell_i.dvs});
    cell_nxt.rem = ge ? diff[31:0] : t[31:0];
    cell_nxt.lo  = {cell_i.lo[30:0], 1'b0};
    cell_nxt.q   = {cell_i.q[30:0], ge};
    cell_nxt.dvs = cell_i.dvs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

[design/snr_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// scales a 64-bit signed 3-vector to a q2.30 unit vector
module snr_unit (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] vec_i  [3],
  output logic signed [31:0] unit_o [3],
  output logic               zero_o
);

  typedef struct packed {
    logic [2:0][31:0] m;
    logic [2:0]       sgn;
    logic             zero;
  } sqsb_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic       zero;
  } dvsb_t;

  logic [63:0]        mag1_nxt [3];
  logic [63:0]        mx1_nxt;
  logic [63:0]        mag1_r   [3];
  logic [63:0]        mx1_r;
  logic [2:0]         sgn1_r;

  logic [63:0]        mag2_r   [3];
  logic [5:0]         pos2_r;
  logic [2:0]         sgn2_r;
  logic               zero2_r;

  logic [5:0]         shr;
  logic [5:0]         shl;
  logic [63:0]        sh3_nxt  [3];
  logic [63:0]        mxs3_nxt;
  logic [31:0]        m3_r     [3];
  logic [31:0]        mx3_r;
  logic [2:0]         sgn3_r;
  logic               zero3_r;

  logic [31:0]        m4_r     [3];
  logic [2:0]         sgn4_r;
  logic               zero4_r;

  logic [63:0]        sq5_r    [3];
  logic [31:0]        m5_r     [3];
  logic [2:0]         sgn5_r;
  logic               zero5_r;

  logic [63:0]        s6_r;
  sqsb_t              sb6_r;

  snr_pkg::sq_t       sq_chain [snr_pkg::SQRT_STEPS+1];
  sqsb_t              sqsb_r   [snr_pkg::SQRT_STEPS];
  snr_pkg::dv_t       dv_chain [3][snr_pkg::DIV_STEPS+1];
  dvsb_t              dvsb_r   [snr_pkg::DIV_STEPS];
  logic [31:0]        root;
  logic [63:0]        dvd      [3];
  logic signed [31:0] unit_nxt [3];
  logic signed [31:0] unit_r   [3];
  logic               zero_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1_nxt[i] = vec_i[i][63] ? 64'(-vec_i[i]) : 64'(vec_i[i]);
    end
    mx1_nxt = mag1_nxt[0];
    if (mag1_nxt[1] > mx1_nxt) begin
      mx1_nxt = mag1_nxt[1];
    end
    if (mag1_nxt[2] > mx1_nxt) begin
      mx1_nxt = mag1_nxt[2];
    end
  end

  // bring the top bit of the largest magnitude to bit 31 or bit 30 of a 32-bit word
  always_comb begin
    shr = 6'(pos2_r - 6'd31);
    shl = 6'(6'd30 - pos2_r);
    for (int i = 0; i < 3; i++) begin
      sh3_nxt[i] = (pos2_r >= 6'd31) ? (mag2_r[i] >> shr) : (mag2_r[i] << shl);
    end
    mxs3_nxt = sh3_nxt[0];
    if (sh3_nxt[1] > mxs3_nxt) begin
      mxs3_nxt = sh3_nxt[1];
    end
    if (sh3_nxt[2] > mxs3_nxt) begin
      mxs3_nxt = sh3_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= mag1_nxt[i];
        sgn1_r[i] <= vec_i[i][63];
        mag2_r[i] <= mag1_r[i];
        m3_r[i]   <= sh3_nxt[i][31:0];
        m4_r[i]   <= (mx3_r > 32'h8000_0000) ? (m3_r[i] >> 1) : m3_r[i];
        sq5_r[i]  <= m4_r[i] * m4_r[i];
        m5_r[i]   <= m4_r[i];
        unit_r[i] <= unit_nxt[i];
      end
      mx1_r      <= mx1_nxt;
      pos2_r     <= snr_pkg::msb_pos(mx1_r);
      zero2_r    <= (mx1_r == '0);
      sgn2_r     <= sgn1_r;
      mx3_r      <= mxs3_nxt[31:0];
      sgn3_r     <= sgn2_r;
      zero3_r    <= zero2_r;
      sgn4_r     <= sgn3_r;
      zero4_r    <= zero3_r;
      sgn5_r     <= sgn4_r;
      zero5_r    <= zero4_r;
      s6_r       <= sq5_r[0] + sq5_r[1] + sq5_r[2];
      sb6_r.m    <= {m5_r[2], m5_r[1], m5_r[0]};
      sb6_r.sgn  <= sgn5_r;
      sb6_r.zero <= zero5_r;
      sqsb_r[0]  <= sb6_r;
      for (int i = 1; i < snr_pkg::SQRT_STEPS; i++) begin
        sqsb_r[i] <= sqsb_r[i-1];
      end
      dvsb_r[0].sgn  <= sqsb_r[snr_pkg::SQRT_STEPS-1].sgn;
      dvsb_r[0].zero <= sqsb_r[snr_pkg::SQRT_STEPS-1].zero;
      for (int i = 1; i < snr_pkg::DIV_STEPS; i++) begin
        dvsb_r[i] <= dvsb_r[i-1];
      end
      zero_r <= dvsb_r[snr_pkg::DIV_STEPS-1].zero;
    end
  end

  assign sq_chain[0] = '{x: s6_r, rem: '0, root: '0};
  assign root        = sq_chain[snr_pkg::SQRT_STEPS].root;

  genvar g, h;
  generate
    for (g = 0; g < snr_pkg::SQRT_STEPS; g++) begin : g_sq
      snr_sqrt_cell u_cell (
        .clk    (clk),
        .en     (en),
        .cell_i (sq_chain[g]),
        .cell_o (sq_chain[g+1])
      );
    end
    for (h = 0; h < 3; h++) begin : g_lane
      assign dvd[h] = (64'(sqsb_r[snr_pkg::SQRT_STEPS-1].m[h]) << 30) + 64'(root[31:1]);
      assign dv_chain[h][0] = '{rem: dvd[h][63:32], lo: dvd[h][31:0], q: '0, dvs: root};
      for (g = 0; g < snr_pkg::DIV_STEPS; g++) begin : g_dv
        snr_div_cell u_cell (
          .clk    (clk),
          .en     (en),
          .cell_i (dv_chain[h][g]),
          .cell_o (dv_chain[h][g+1])
        );
      end
      assign unit_nxt[h] = dvsb_r[snr_pkg::DIV_STEPS-1].zero ? 32'sd0 :
                           dvsb_r[snr_pkg::DIV_STEPS-1].sgn[h] ?
                           $signed(32'(-dv_chain[h][snr_pkg::DIV_STEPS].q)) :
                           $signed(dv_chain[h][snr_pkg::DIV_STEPS].q);
      assign unit_o[h] = unit_r[h];
    end
  endgenerate

  assign zero_o = zero_r;

endmodule
`default_nettype wire

[design/snell_refraction_vector.sv]
// snell_refraction_vector: refracts a ray direction at a surface, vector form of snell's law
// in: one word per ray on in_tvalid/in_tready/in_tdata, holding direction, normal and
//   the two refractive indices (unsigned q2.30)
// out: one word per ray on out_tvalid/out_tready/out_tdata, the unit direction in q2.30,
//   with total_reflect and degenerate in out_tuser
// the path is two unit-scaling passes in series (direction and normal side by side, then
//   the result), each a 32-cell root row and three 32-cell divider rows, one per component,
//   with the dot, the sine root beside the eta divider, the cosine root and the multiply
//   and add stages between them
// throughput is one word per cycle unless the receiver stalls, every stage is a register that advances together
// when the receiver stalls with a word waiting, the whole row of cells holds and
//   in_tready drops in the same cycle; it rises again as soon as the word is taken
// reset clears the valid marks of every stage; no word is in flight after it
`timescale 1ns / 1ps
`default_nettype none
`include "snell_refraction_vector_macros.svh"
module snell_refraction_vector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_from, index_to
  input  logic [snr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_x, out_y, out_z
  output logic [snr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // total_reflect, degenerate
  output logic [snr_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  typedef struct packed {
    logic [31:0] from;
    logic [31:0] to;
  } idx_t;

  typedef struct packed {
    logic [31:0]      c1;
    logic [2:0][31:0] d;
    logic [2:0][31:0] n;
    logic             ovf;
    logic             deg;
  } cs_t;

  typedef struct packed {
    logic [32:0]      ec1;
    logic             tir;
    logic [31:0]      eta;
    logic [31:0]      c1;
    logic [2:0][31:0] d;
    logic [2:0][31:0] n;
    logic             deg;
  } ds_t;

  typedef struct packed {
    logic tir;
    logic deg;
  } fl_t;

  logic                        adv;
  logic [snr_pkg::TOP_LAT-1:0] vld_r;

  logic signed [63:0] dvec [3];
  logic signed [63:0] nvec [3];
  logic signed [31:0] du   [3];
  logic signed [31:0] nu   [3];
  logic               dzero;
  logic               nzero;
  idx_t               idx_r [snr_pkg::UNIT_LAT];

  // stage 1: products of the dot
  logic signed [63:0] prod1_nxt [3];
  logic signed [63:0] prod1_r   [3];
  logic [2:0][31:0]   d1_r;
  logic [2:0][31:0]   n1_r;
  idx_t               idx1_r;
  logic               deg1_r;

  // stage 2: dot
  logic signed [63:0] dot2_r;
  logic [2:0][31:0]   d2_r;
  logic [2:0][31:0]   n2_r;
  idx_t               idx2_r;
  logic               deg2_r;

  // stage 3: flip, c1
  logic [63:0]        dmag;
  logic [63:0]        c1w;
  logic [31:0]        c1_3_nxt;
  logic [31:0]        c1_3_r;
  logic [2:0][31:0]   d3_r;
  logic [2:0][31:0]   n3_r;
  idx_t               idx3_r;
  logic               deg3_r;

  // stage 4: c1 squared, eta dividend
  logic [63:0]        dvd4_nxt;
  logic [63:0]        c1sq4_r;
  logic [63:0]        dvd4_r;
  logic [31:0]        to4_r;
  cs_t                cs4_r;

  snr_pkg::sq_t       sa_chain [snr_pkg::SQRT_STEPS+1];
  snr_pkg::dv_t       ea_chain [snr_pkg::DIV_STEPS+1];
  cs_t                cs_r     [snr_pkg::SQRT_STEPS];
  cs_t                cs_end;
  snr_pkg::sq_t       sa_end;

  // stage 5..8
  logic [31:0]        eta5_r;
  logic [31:0]        sin1_5_r;
  cs_t                cs5_r;
  logic [63:0]        p6_r;
  logic [63:0]        ec1p6_r;
  logic [31:0]        eta6_r;
  cs_t                cs6_r;
  logic [63:0]        s2w;
  logic [63:0]        ec1w;
  logic [31:0]        s2_7_r;
  ds_t                ds7_r;
  logic [63:0]        s2sq8_r;
  ds_t                ds8_r;

  snr_pkg::sq_t       sb_chain [snr_pkg::SQRT_STEPS+1];
  ds_t                ds_r     [snr_pkg::SQRT_STEPS];
  ds_t                ds_end;
  snr_pkg::sq_t       sb_end;

  // stage 9..11
  logic [31:0]        cos2;
  logic signed [34:0] k9_nxt;
  logic signed [34:0] k9_r;
  ds_t                ds9_r;
  logic signed [34:0] coef;
  logic signed [66:0] bw   [3];
  logic signed [64:0] aw   [3];
  logic signed [63:0] a10_nxt [3];
  logic signed [63:0] a10_r   [3];
  logic signed [63:0] b10_r   [3];
  fl_t                fl10_r;
  logic signed [63:0] res11_r [3];
  fl_t                fl11_r;
  fl_t                fl_r    [snr_pkg::UNIT_LAT];
  fl_t                fl_out;
  logic signed [31:0] ur      [3];
  logic               rzero;
  logic               unit_ok;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[snr_pkg::TOP_LAT-2:0], in_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvec[i] = 64'(signed'(in_tdata[32*i +: 32]));
      nvec[i] = 64'(signed'(in_tdata[96 + 32*i +: 32]));
    end
  end

  snr_unit u_unit_d (.clk(clk), .en(adv), .vec_i(dvec), .unit_o(du), .zero_o(dzero));
  snr_unit u_unit_n (.clk(clk), .en(adv), .vec_i(nvec), .unit_o(nu), .zero_o(nzero));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod1_nxt[i] = du[i] * nu[i];
    end
    dmag     = dot2_r[63] ? 64'(-dot2_r) : 64'(dot2_r);
    c1w      = (dmag + snr_pkg::HALF_Q30) >> 30;
    c1_3_nxt = (c1w > 64'(snr_pkg::ONE_Q30)) ? snr_pkg::ONE_Q30 : c1w[31:0];
    dvd4_nxt = (64'(idx3_r.from) << 30) + 64'(idx3_r.to[31:1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r[0] <= '{from: in_tdata[223:192], to: in_tdata[255:224]};
      for (int i = 1; i < snr_pkg::UNIT_LAT; i++) begin
        idx_r[i] <= idx_r[i-1];
      end
      for (int i = 0; i < 3; i++) begin
        prod1_r[i] <= prod1_nxt[i];
        d1_r[i]    <= du[i];
        n1_r[i]    <= nu[i];
        d3_r[i]    <= d2_r[i];
        n3_r[i]    <= dot2_r[63] ? 32'(-n2_r[i]) : n2_r[i];
      end
      idx1_r  <= idx_r[snr_pkg::UNIT_LAT-1];
      deg1_r  <= dzero || nzero;
      dot2_r  <= prod1_r[0] + prod1_r[1] + prod1_r[2];
      d2_r    <= d1_r;
      n2_r    <= n1_r;
      idx2_r  <= idx1_r;
      deg2_r  <= deg1_r;
      c1_3_r  <= c1_3_nxt;
      idx3_r  <= dot2_r[63] ? idx_t'{from: idx2_r.to, to: idx2_r.from} : idx2_r;
      deg3_r  <= deg2_r;
      c1sq4_r <= c1_3_r * c1_3_r;
      dvd4_r  <= dvd4_nxt;
      to4_r   <= idx3_r.to;
      cs4_r   <= '{c1: c1_3_r, d: d3_r, n: n3_r,
                   ovf: (idx3_r.to == '0) || (dvd4_nxt[63:32] >= idx3_r.to),
                   deg: deg3_r};
      cs_r[0] <= cs4_r;
      for (int i = 1; i < snr_pkg::SQRT_STEPS; i++) begin
        cs_r[i] <= cs_r[i-1];
      end
    end
  end

  assign sa_chain[0] = '{x: snr_pkg::ONE_Q60 - c1sq4_r, rem: '0, root: '0};
  assign ea_chain[0] = '{rem: dvd4_r[63:32], lo: dvd4_r[31:0], q: '0, dvs: to4_r};
  assign cs_end      = cs_r[snr_pkg::SQRT_STEPS-1];
  assign sa_end      = sa_chain[snr_pkg::SQRT_STEPS];

  genvar g;
  generate
    for (g = 0; g < snr_pkg::SQRT_STEPS; g++) begin : g_sin
      snr_sqrt_cell u_cell (
        .clk    (clk),
        .en     (adv),
        .cell_i (sa_chain[g]),
        .cell_o (sa_chain[g+1])
      );
    end
    for (g = 0; g < snr_pkg::DIV_STEPS; g++) begin : g_eta
      snr_div_cell u_cell (
        .clk    (clk),
        .en     (adv),
        .cell_i (ea_chain[g]),
        .cell_o (ea_chain[g+1])
      );
    end
    for (g = 0; g < snr_pkg::SQRT_STEPS; g++) begin : g_cos
      snr_sqrt_cell u_cell (
        .clk    (clk),
        .en     (adv),
        .cell_i (sb_chain[g]),
        .cell_o (sb_chain[g+1])
      );
    end
  endgenerate

  always_comb begin
    s2w  = (p6_r + snr_pkg::HALF_Q30) >> 30;
    ec1w = (ec1p6_r + snr_pkg::HALF_Q30) >> 30;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eta5_r   <= cs_end.ovf ? snr_pkg::ETA_MAX : ea_chain[snr_pkg::DIV_STEPS].q;
      sin1_5_r <= sa_end.root + 32'({2'b00, sa_end.root} < sa_end.rem);
      cs5_r    <= cs_end;
      p6_r     <= eta5_r * sin1_5_r;
      ec1p6_r  <= eta5_r * cs5_r.c1;
      eta6_r   <= eta5_r;
      cs6_r    <= cs5_r;
      s2_7_r   <= s2w[31:0];
      ds7_r    <= '{ec1: ec1w[32:0], tir: (p6_r >= snr_pkg::ONE_Q60), eta: eta6_r,
                    c1: cs6_r.c1, d: cs6_r.d, n: cs6_r.n, deg: cs6_r.deg};
      s2sq8_r  <= s2_7_r * s2_7_r;
      ds8_r    <= ds7_r;
      ds_r[0]  <= ds8_r;
      for (int i = 1; i < snr_pkg::SQRT_STEPS; i++) begin
        ds_r[i] <= ds_r[i-1];
      end
    end
  end

  assign sb_chain[0] = '{x: snr_pkg::ONE_Q60 - s2sq8_r, rem: '0, root: '0};
  assign ds_end      = ds_r[snr_pkg::SQRT_STEPS-1];
  assign sb_end      = sb_chain[snr_pkg::SQRT_STEPS];

  always_comb begin
    cos2   = sb_end.root + 32'({2'b00, sb_end.root} < sb_end.rem);
    k9_nxt = $signed({3'b000, cos2}) - $signed({2'b00, ds_end.ec1});
    coef   = ds9_r.tir ? -$signed({2'b00, ds9_r.c1, 1'b0}) : k9_r;
    for (int i = 0; i < 3; i++) begin
      bw[i]      = coef * $signed(ds9_r.n[i]);
      aw[i]      = $signed({1'b0, ds9_r.eta}) * $signed(ds9_r.d[i]);
      a10_nxt[i] = ds9_r.tir ? $signed({{2{ds9_r.d[i][31]}}, ds9_r.d[i], 30'b0}) :
                   aw[i][63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k9_r  <= k9_nxt;
      ds9_r <= ds_end;
      for (int i = 0; i < 3; i++) begin
        a10_r[i]   <= a10_nxt[i];
        b10_r[i]   <= bw[i][63:0];
        res11_r[i] <= fl10_r.deg ? 64'sd0 : a10_r[i] + b10_r[i];
      end
      fl10_r   <= '{tir: ds9_r.tir && !ds9_r.deg, deg: ds9_r.deg};
      fl11_r   <= fl10_r;
      fl_r[0]  <= fl11_r;
      for (int i = 1; i < snr_pkg::UNIT_LAT; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  snr_unit u_unit_r (.clk(clk), .en(adv), .vec_i(res11_r), .unit_o(ur), .zero_o(rzero));

  assign fl_out                         = fl_r[snr_pkg::UNIT_LAT-1];
  assign out_tvalid                     = vld_r[snr_pkg::TOP_LAT-1];
  assign out_tdata                      = {ur[2] & {32{!rzero}}, ur[1], ur[0]};
  assign out_tuser[snr_pkg::TUSER_TIR]  = fl_out.tir;
  assign out_tuser[snr_pkg::TUSER_DEG]  = fl_out.deg;

  // every component of the result within plus or minus one
  always_comb begin
    unit_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ((ur[i] > 32'sh4000_0000) || (ur[i] < -32'sh4000_0000)) begin
        unit_ok = 1'b0;
      end
    end
  end

  `SNR_ASSERT_IMP(a_deg_zero, out_tvalid && fl_out.deg, out_tdata == '0 && !fl_out.tir)
  `SNR_ASSERT_IMP(a_unit_range, out_tvalid, unit_ok)
  `SNR_ASSERT_NXT(a_stall_holds, out_tvalid && !out_tready, $stable(vld_r))

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for snell_refraction_vector: directed and random rays against a predictor
module tb;

  typedef bit [63:0] u64;
  typedef struct {
    bit [95:0] dir_out;
    bit [1:0]  flags;
  } ray_result_t;

  localparam int LIMIT = 400000;
  localparam int N_RAND = 930;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [snr_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [snr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [snr_pkg::OUT_TUSER_W-1:0] out_tuser;

  logic [snr_pkg::IN_TDATA_W-1:0] ray_queue[$];
  ray_result_t expected_rays[$];
  int errors = 0;
  int cycles = 0;
  int n_out = 0;
  int hold_cnt = 0;
  bit held = 0;
  bit calm;

  snell_refraction_vector u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // a long run of words with no idling on either side
  assign calm = (n_out >= 500) && (n_out < 800);

  function automatic u64 isqrt_down(u64 x);
    u64 r, b;
    r = 0;
    b = u64'(1) << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic u64 isqrt_round(u64 x);
    u64 r;
    r = isqrt_down(x);
    if (x - r * r > r) r++;
    return r;
  endfunction

  function automatic u64 magn(longint v);
    return v < 0 ? u64'(0) - u64'(v) : u64'(v);
  endfunction

  function automatic bit to_unit(input longint v[3], output longint u[3]);
    u64 m[3];
    u64 mx, s, r, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = magn(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 0;
    end
    while (mx > (u64'(1) << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (u64'(1) << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = isqrt_down(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (r >> 1)) / r;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic ray_result_t refract_ray(logic [snr_pkg::IN_TDATA_W-1:0] w);
    ray_result_t res;
    longint dv[3], nv[3], d[3], n[3], rv[3], u[3];
    longint dotp, k;
    u64 from, to, tmp, c1, eta, sin1, p, s2, cos2, ec1;
    bit tir, deg, ok_d, ok_n;
    tir = 0;
    deg = 0;
    from = u64'(w[192 +: 32]);
    to = u64'(w[224 +: 32]);
    for (int i = 0; i < 3; i++) begin
      dv[i] = longint'($signed(w[i*32 +: 32]));
      nv[i] = longint'($signed(w[96 + i*32 +: 32]));
    end
    ok_d = to_unit(dv, d);
    ok_n = to_unit(nv, n);
    if (!ok_d || !ok_n) begin
      deg = 1;
      for (int i = 0; i < 3; i++) u[i] = 0;
    end else begin
      dotp = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
      if (dotp < 0) begin
        tmp = from;
        from = to;
        to = tmp;
        for (int i = 0; i < 3; i++) n[i] = -n[i];
      end
      c1 = (magn(dotp) + u64'(snr_pkg::HALF_Q30)) >> 30;
      if (c1 > u64'(snr_pkg::ONE_Q30)) c1 = u64'(snr_pkg::ONE_Q30);
      if (to == 0) begin
        eta = u64'(snr_pkg::ETA_MAX);
      end else begin
        eta = ((from << 30) + (to >> 1)) / to;
        if (eta > u64'(snr_pkg::ETA_MAX)) eta = u64'(snr_pkg::ETA_MAX);
      end
      sin1 = isqrt_round(u64'(snr_pkg::ONE_Q60) - c1 * c1);
      p = eta * sin1;
      if (p >= u64'(snr_pkg::ONE_Q60)) begin
        tir = 1;
        for (int i = 0; i < 3; i++)
          rv[i] = d[i] * longint'(snr_pkg::ONE_Q30) - 2 * longint'(c1) * n[i];
      end else begin
        s2 = (p + u64'(snr_pkg::HALF_Q30)) >> 30;
        cos2 = isqrt_round(u64'(snr_pkg::ONE_Q60) - s2 * s2);
        ec1 = (eta * c1 + u64'(snr_pkg::HALF_Q30)) >> 30;
        k = longint'(cos2) - longint'(ec1);
        for (int i = 0; i < 3; i++) rv[i] = longint'(eta) * d[i] + k * n[i];
      end
      void'(to_unit(rv, u));
    end
    for (int i = 0; i < 3; i++) res.dir_out[i*32 +: 32] = u[i][31:0];
    res.flags[snr_pkg::TUSER_TIR] = tir;
    res.flags[snr_pkg::TUSER_DEG] = deg;
    return res;
  endfunction

  function automatic logic [snr_pkg::IN_TDATA_W-1:0] pack_ray(bit [31:0] dx, bit [31:0] dy,
      bit [31:0] dz, bit [31:0] nx, bit [31:0] ny, bit [31:0] nz,
      bit [31:0] from, bit [31:0] to);
    return {to, from, nz, ny, nx, dz, dy, dx};
  endfunction

  function automatic bit [31:0] rand_comp(int mode);
    bit [31:0] v;
    v = $urandom;
    case (mode)
      0: return v;
      1: return 32'($signed(v) >>> $urandom_range(31, 0));
      2: return 32'($signed(v) >>> 20);
      default: return (v[0] ? 32'hFFFF_FFFF : 32'h0) ^ {31'd0, v[1]};
    endcase
  endfunction

  function automatic bit [31:0] rand_index();
    case ($urandom_range(9, 0))
      0: return $urandom;
      1: return $urandom_range(32'h3FFF_FFFF, 0);
      default: return $urandom_range(32'hC000_0000, 32'h4000_0000);
    endcase
  endfunction

  function automatic logic [snr_pkg::IN_TDATA_W-1:0] rand_ray();
    bit [31:0] c[6];
    int md, mn;
    md = $urandom_range(3, 0);
    mn = $urandom_range(3, 0);
    for (int i = 0; i < 3; i++) c[i] = rand_comp(md);
    for (int i = 3; i < 6; i++) c[i] = rand_comp(mn);
    if ($urandom_range(49, 0) == 0) begin
      if ($urandom_range(1, 0)) {c[0], c[1], c[2]} = '0;
      else {c[3], c[4], c[5]} = '0;
    end
    return pack_ray(c[0], c[1], c[2], c[3], c[4], c[5], rand_index(), rand_index());
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) expected_rays.push_back(refract_ray(in_tdata));
    if (!in_tvalid || in_tready) begin
      if (rst_n && ray_queue.size() > 0 && (calm || $urandom_range(99, 0) >= 9)) begin
        in_tvalid <= 1'b1;
        in_tdata <= ray_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk) begin
    if (!held && n_out == 300) begin
      held <= 1;
      hold_cnt <= 600;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && (calm || $urandom_range(99, 0) >= 9);
    end
  end

  // monitor
  always @(posedge clk) begin
    ray_result_t e;
    cycles <= cycles + 1;
    if (out_tvalid && out_tready) begin
      n_out <= n_out + 1;
      if (expected_rays.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected word %h / %b", $time, out_tdata, out_tuser);
      end else begin
        e = expected_rays.pop_front();
        if (out_tdata !== e.dir_out || out_tuser !== e.flags) begin
          errors <= errors + 1;
          $display("%0t: mismatch expected %h / %b actual %h / %b", $time,
                   e.dir_out, e.flags, out_tdata, out_tuser);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("snell_refraction_vector test failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // zero direction, zero normal
    ray_queue.push_back(pack_ray(0, 0, 0, 0, 32'h4000_0000, 0, 32'h4000_0000, 32'h6000_0000));
    ray_queue.push_back(pack_ray(1, 2, 3, 0, 0, 0, 32'h4000_0000, 32'h4000_0000));
    // extremes of the components
    ray_queue.push_back(pack_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'hFFFF_FFFF, 32'h4000_0000));
    ray_queue.push_back(pack_ray(32'h7FFF_FFFF, 0, 32'h8000_0000, 1, 32'hFFFF_FFFF, 0,
                                 32'h4000_0000, 32'hFFFF_FFFF));
    // head-on, both orientations of the normal
    ray_queue.push_back(pack_ray(0, 0, 5, 0, 0, 1, 32'h4000_0000, 32'h6000_0000));
    ray_queue.push_back(pack_ray(0, 0, 5, 0, 0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h6000_0000));
    // grazing, dot product of zero
    ray_queue.push_back(pack_ray(1, 0, 0, 0, 0, 1, 32'h6000_0000, 32'h4000_0000));
    // glass to air at a shallow angle, total internal reflection
    ray_queue.push_back(pack_ray(100, 0, 20, 0, 0, 1, 32'h6000_0000, 32'h4000_0000));
    ray_queue.push_back(pack_ray(100, 0, 32'hFFFF_FFEC, 0, 0, 1, 32'h4000_0000,
                                 32'h6000_0000));
    // air to water, oblique
    ray_queue.push_back(pack_ray(3, 4, 5, 0, 1, 1, 32'h4000_0000, 32'h5555_5555));
    // zero index on either side, indices below one
    ray_queue.push_back(pack_ray(3, 4, 5, 0, 1, 1, 32'h4000_0000, 0));
    ray_queue.push_back(pack_ray(3, 4, 32'hFFFF_FFFB, 0, 1, 1, 0, 32'h4000_0000));
    ray_queue.push_back(pack_ray(7, 1, 9, 2, 3, 4, 32'h1000_0000, 32'h0000_0001));
    ray_queue.push_back(pack_ray(7, 1, 9, 2, 3, 4, 0, 0));
    // equal indices, straight through
    ray_queue.push_back(pack_ray(32'h1234_5678, 32'hEDCB_A987, 32'h0FFF_0000,
                                 11, 22, 33, 32'h5000_0000, 32'h5000_0000));
    // the sender stops until the block has drained
    while (ray_queue.size() > 0 || in_tvalid || expected_rays.size() > 0) @(posedge clk);
    for (int i = 0; i < N_RAND; i++) ray_queue.push_back(rand_ray());
    while (ray_queue.size() > 0 || in_tvalid || expected_rays.size() > 0) @(posedge clk);
    repeat (snr_pkg::TOP_LAT + 50) @(posedge clk);
    if (errors == 0) begin
      $display("snell_refraction_vector test passed");
    end else begin
      $display("snell_refraction_vector test failed");
    end
    $finish;
  end
endmodule
